// ===== sv/assert_macros.svh =====
// Assertion macros shared by the verification checkers.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/mbtcp_pkg.sv =====
// Types and constants of the Modbus TCP request deframer.
// No dependencies.
package mbtcp_pkg;

    localparam int POS_W      = 17;
    localparam int HDR_KEEP   = 12;
    localparam int HDR_IDX_W  = 4;
    localparam int LEN_HI_POS = 4;
    localparam int LEN_LO_POS = 5;
    localparam int UNIT_POS   = 6;
    localparam int FUNC_POS   = 7;
    localparam int MBAP_LEN   = 6;

    localparam logic [7:0] FC_READ_COILS    = 8'h01;
    localparam logic [7:0] FC_READ_INPUTS   = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_FORCE_COIL    = 8'h05;
    localparam logic [7:0] FC_WRITE_REG     = 8'h06;

    typedef enum logic [2:0] {
        KIND_READ_HOLDING = 3'd0,
        KIND_WRITE_REG    = 3'd1,
        KIND_READ_COILS   = 3'd2,
        KIND_FORCE_COIL   = 3'd3,
        KIND_READ_INPUTS  = 3'd4
    } kind_t;

    typedef struct packed {
        logic  ok;
        kind_t kind;
    } fc_dec_t;

    typedef struct packed {
        logic [15:0] transaction_id;
        logic [15:0] protocol_id;
        logic [7:0]  unit_id;
        kind_t       request_kind;
        logic [15:0] item_address;
        logic [15:0] count_or_value;
    } req_t;

    function automatic fc_dec_t decode_fc(input logic [7:0] fc);
        fc_dec_t d;
        d.ok   = 1'b1;
        d.kind = KIND_READ_HOLDING;
        unique case (fc)
            FC_READ_HOLDING: d.kind = KIND_READ_HOLDING;
            FC_WRITE_REG:    d.kind = KIND_WRITE_REG;
            FC_READ_COILS:   d.kind = KIND_READ_COILS;
            FC_FORCE_COIL:   d.kind = KIND_FORCE_COIL;
            FC_READ_INPUTS:  d.kind = KIND_READ_INPUTS;
            default:         d.ok   = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/mbtcp_core.sv =====
// Frame tracking and header capture: byte counter, frame length, header bytes.
// Depends on mbtcp_pkg.
module mbtcp_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     data_byte,
    output logic           res_valid,
    output mbtcp_pkg::req_t res
);
    import mbtcp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic [7:0]       hdr_reg [HDR_KEEP];
    logic             frame_end;
    logic [7:0]       byte11;
    fc_dec_t          fc;

    always_comb
    begin
        total_next = total_reg;
        if (pos_reg == POS_W'(LEN_LO_POS))
        begin
            total_next = POS_W'(MBAP_LEN) + {1'b0, hdr_reg[LEN_HI_POS], data_byte};
        end
        frame_end = (pos_reg >= POS_W'(LEN_LO_POS)) && (pos_reg + 1'b1 == total_next);
        pos_next  = frame_end ? '0 : pos_reg + 1'b1;
        byte11    = (pos_reg == POS_W'(HDR_KEEP - 1)) ? data_byte : hdr_reg[HDR_KEEP - 1];
        fc        = decode_fc(hdr_reg[FUNC_POS]);

        res.transaction_id = {hdr_reg[0], hdr_reg[1]};
        res.protocol_id    = {hdr_reg[2], hdr_reg[3]};
        res.unit_id        = hdr_reg[UNIT_POS];
        res.request_kind   = fc.kind;
        res.item_address   = {hdr_reg[8], hdr_reg[9]};
        res.count_or_value = {hdr_reg[10], byte11};
        res_valid = accept && frame_end && fc.ok && (total_next >= POS_W'(HDR_KEEP));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg < POS_W'(HDR_KEEP)))
        begin
            hdr_reg[pos_reg[HDR_IDX_W-1:0]] <= data_byte;
        end
    end

endmodule

// ===== sv/mbtcp_out_skid.sv =====
// Output register with one skid entry for request records.
// Depends on mbtcp_pkg.
module mbtcp_out_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_valid,
    input  mbtcp_pkg::req_t res,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output mbtcp_pkg::req_t out_data
);
    import mbtcp_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    req_t out_reg;
    req_t skid_reg;
    logic out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

endmodule

// ===== sv/modbus_tcp_request_deframer.sv =====
// Modbus TCP request deframer, top level.
// Depends on mbtcp_pkg, mbtcp_core and mbtcp_out_skid.
//
// Input channel: one stream byte per transaction on data_byte, in_valid/in_stall.
// Output channel: one request record per transaction, out_valid/out_stall,
// each field on a port of its own.
// A frame is 6 + L bytes, L taken from header bytes 4-5. On the last byte of a
// frame of at least 12 bytes with function code 1, 2, 3, 5 or 6 one record is
// produced; any other frame is consumed and dropped without output.
// Throughput: one byte per cycle while in_stall is low. The record is
// registered in the output register, or in the skid entry when the output
// stalls, and from the output register it appears on out_valid.
// Reset clears the byte counter and frame length; the stream starts with a
// new frame. When the receiver stalls, the record holds in the output
// register and one more record fits in a skid entry; in_stall rises only
// while that entry is occupied.
module modbus_tcp_request_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] transaction_id,
    output logic [15:0] protocol_id,
    output logic [7:0]  unit_id,
    output logic [2:0]  request_kind,
    output logic [15:0] item_address,
    output logic [15:0] count_or_value
);
    import mbtcp_pkg::*;

    logic accept;
    logic res_valid;
    logic full;
    req_t res;
    req_t out_data;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    mbtcp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    mbtcp_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign transaction_id = out_data.transaction_id;
    assign protocol_id    = out_data.protocol_id;
    assign unit_id        = out_data.unit_id;
    assign request_kind   = 3'(out_data.request_kind);
    assign item_address   = out_data.item_address;
    assign count_or_value = out_data.count_or_value;

endmodule

// ===== sv/mbtcp_checker.sv =====
// Port-level checks for the Modbus TCP request deframer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mbtcp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] transaction_id,
    input logic [15:0] protocol_id,
    input logic [7:0]  unit_id,
    input logic [2:0]  request_kind,
    input logic [15:0] item_address,
    input logic [15:0] count_or_value
);

    logic [74:0] rec_bits;

    assign rec_bits = {transaction_id, protocol_id, unit_id, request_kind,
                       item_address, count_or_value};

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(rec_bits))
    `ASSERT_IMPLY(a_kind_range, clk, rst_n, out_valid, request_kind <= 3'd4)
    `ASSERT_IMPLY(a_stall_needs_out, clk, rst_n, in_stall, out_valid)
    `ASSERT_IMPLY(a_rec_from_byte, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall))

endmodule

bind modbus_tcp_request_deframer mbtcp_checker u_mbtcp_checker (.*);
